/* hdl/jrsq_pkg.sv */
// ----------------------------------------------------------------------------
// jrsq_pkg
// Shared types, codes and constants of the join request sequencer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package jrsq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int HANDLE_BITS_DEF = 8;

	localparam int CHANNEL_W = 8;
	localparam int TARGET_W  = 8;
	localparam int KIND_W    = 3;
	localparam int CMD_W     = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;
	localparam int PERIOD_W  = 32;
	localparam int MASK_W    = 5;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd1000;

	// command codes
	localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REM  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLR  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_TICK = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIS_MASK  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HAS_IE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IE_NEEDOP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HAS_Q     = 3'd4;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_MODE = 3'd0;
	localparam logic [KIND_W-1:0] KIND_E    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_I    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_Q    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_WHO  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_B    = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK,
		ST_RDHEAD,
		ST_HEAD,
		ST_ENQ_SCAN,
		ST_REM_SCAN,
		ST_SHIFT,
		ST_OUT
	} jrsq_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic wipe;
		logic scan_start;
		logic scan_step;
		logic shift_wr;
		logic shift_start;
		logic append;
		logic remove_done;
		logic tick;
		logic head_read;
		logic emit;
		logic drop_head;
	} jrsq_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic running;
		logic expire;
		logic fill_zero;
		logic fill_one;
		logic full;
		logic hit;
		logic scan_end;
		logic stage_zero;
		logic kind_found;
	} jrsq_sts_t;

	function automatic logic kind_allowed(
		input logic [KIND_W-1:0] kind,
		input logic              op,
		input logic [MASK_W-1:0] mask,
		input logic              has_ie,
		input logic              ie_needs_op,
		input logic              has_q
	);
		logic ie_ok;
		logic ok;
		ie_ok = has_ie && !(ie_needs_op && !op);
		case (kind)
			KIND_E:   ok = ie_ok && !mask[0];
			KIND_I:   ok = ie_ok && !mask[1];
			KIND_Q:   ok = has_q && !mask[2];
			KIND_WHO: ok = !mask[3];
			KIND_B:   ok = !mask[4];
			default:  ok = 1'b0;
		endcase
		return ok;
	endfunction

endpackage

`default_nettype wire

/* hdl/join_request_sequencer_queue.sv */
// ----------------------------------------------------------------------------
// join_request_sequencer_queue
// Paced queue of channel handles that issues at most one information request per
// period expiry to the head channel.
// ----------------------------------------------------------------------------
// Handles one item at a time. Enqueue and remove walk the stored handles
// through the single read port of the handle memory, one handle per cycle,
// and stop at a match. A remove that finds its handle then moves the
// handles behind it down by one place. An expiring tick drops each head
// channel that is at the end of its kind list, and any result then waits
// in its output register until taken.
`default_nettype none

module join_request_sequencer_queue #(
	parameter int QUEUE_DEPTH = jrsq_pkg::QUEUE_DEPTH_DEF,
	parameter int HANDLE_BITS = jrsq_pkg::HANDLE_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_write,
	input  wire logic [jrsq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [jrsq_pkg::CFG_DAT_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [jrsq_pkg::CMD_W-1:0]      command,
	input  wire logic [jrsq_pkg::CHANNEL_W-1:0]  channel,
	input  wire logic                            me_op,
	input  wire logic                            link_up,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [jrsq_pkg::KIND_W-1:0]          request_kind,
	output logic [jrsq_pkg::TARGET_W-1:0]        target,
	output logic                                 sent
);
	import jrsq_pkg::*;

	jrsq_ctl_t ctl;
	jrsq_sts_t sts;

	jrsq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	jrsq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.HANDLE_BITS (HANDLE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.channel      (channel),
		.me_op        (me_op),
		.link_up      (link_up),
		.ctl          (ctl),
		.sts          (sts),
		.request_kind (request_kind),
		.target       (target),
		.sent         (sent)
	);

endmodule

`default_nettype wire

/* hdl/jrsq_ctrl.sv */
// ----------------------------------------------------------------------------
// jrsq_ctrl
// Controller state machine: sequences command handling, queue scans,
// removal shifts and the per-expiry request choice.
// ----------------------------------------------------------------------------
`default_nettype none

module jrsq_ctrl (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [jrsq_pkg::CMD_W-1:0] command,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	input  wire jrsq_pkg::jrsq_sts_t     sts,
	output jrsq_pkg::jrsq_ctl_t          ctl
);
	import jrsq_pkg::*;

	jrsq_state_t state_q;
	jrsq_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (command)
						CMD_ENQ:  state_d = ST_ENQ_SCAN;
						CMD_REM:  state_d = ST_REM_SCAN;
						CMD_TICK: state_d = ST_TICK;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_TICK: begin
				if (sts.running && sts.expire && !sts.fill_zero) begin
					state_d = ST_RDHEAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_RDHEAD: state_d = ST_HEAD;
			ST_HEAD: begin
				if (sts.stage_zero || sts.kind_found) begin
					state_d = ST_OUT;
				end else if (sts.fill_one) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_RDHEAD;
				end
			end
			ST_ENQ_SCAN: begin
				if (sts.hit || sts.scan_end) begin
					state_d = ST_IDLE;
				end
			end
			ST_REM_SCAN: begin
				if (sts.hit) begin
					state_d = ST_SHIFT;
				end else if (sts.scan_end) begin
					state_d = ST_IDLE;
				end
			end
			ST_SHIFT: begin
				if (sts.scan_end) begin
					state_d = ST_IDLE;
				end
			end
			ST_OUT: begin
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					case (command)
						CMD_ENQ, CMD_REM: ctl.scan_start = 1'b1;
						CMD_CLR:          ctl.wipe = 1'b1;
						default:          ctl.load = 1'b1;
					endcase
				end
			end
			ST_TICK: ctl.tick = sts.running;
			ST_RDHEAD: ctl.head_read = 1'b1;
			ST_HEAD: begin
				if (sts.stage_zero || sts.kind_found) begin
					ctl.emit = 1'b1;
				end else begin
					// end of the kind list: move on to the next channel
					ctl.drop_head = 1'b1;
				end
			end
			ST_ENQ_SCAN: begin
				if (sts.hit) begin
					ctl.load = 1'b0;
				end else if (sts.scan_end) begin
					ctl.append = !sts.full;
				end else begin
					ctl.scan_step = 1'b1;
				end
			end
			ST_REM_SCAN: begin
				if (sts.hit) begin
					ctl.shift_start = 1'b1;
				end else if (!sts.scan_end) begin
					ctl.scan_step = 1'b1;
				end
			end
			ST_SHIFT: begin
				if (sts.scan_end) begin
					ctl.remove_done = 1'b1;
				end else begin
					ctl.scan_step = 1'b1;
					ctl.shift_wr  = 1'b1;
				end
			end
			ST_OUT: out_valid = 1'b1;
			default: ctl = '0;
		endcase
	end

endmodule

`default_nettype wire

/* hdl/jrsq_dp.sv */
// ----------------------------------------------------------------------------
// jrsq_dp
// Datapath: handle memory kept as a ring, fill count, scan pointer,
// request stage, period counter, configuration and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module jrsq_dp #(
	parameter int QUEUE_DEPTH = jrsq_pkg::QUEUE_DEPTH_DEF,
	parameter int HANDLE_BITS = jrsq_pkg::HANDLE_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_write,
	input  wire logic [jrsq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [jrsq_pkg::CFG_DAT_W-1:0]  cfg_data,
	input  wire logic [jrsq_pkg::CHANNEL_W-1:0]  channel,
	input  wire logic                            me_op,
	input  wire logic                            link_up,
	input  wire jrsq_pkg::jrsq_ctl_t             ctl,
	output jrsq_pkg::jrsq_sts_t                  sts,
	output logic [jrsq_pkg::KIND_W-1:0]          request_kind,
	output logic [jrsq_pkg::TARGET_W-1:0]        target,
	output logic                                 sent
);
	import jrsq_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CH_W  = (HANDLE_BITS > CHANNEL_W) ? HANDLE_BITS : CHANNEL_W;
	localparam int TG_W  = (HANDLE_BITS > TARGET_W) ? HANDLE_BITS : TARGET_W;

	// configuration
	logic [PERIOD_W-1:0] period_q;
	logic [MASK_W-1:0]   mask_q;
	logic                has_ie_q;
	logic                ie_needs_op_q;
	logic                has_q_q;

	// latched item
	logic [HANDLE_BITS-1:0] ch_q;
	logic                   op_q;
	logic                   link_q;

	// queue and sequencing state
	logic [HANDLE_BITS-1:0] fifo_mem [QUEUE_DEPTH];
	logic [HANDLE_BITS-1:0] rdata_q;
	logic [CNT_W-1:0]       fill_q;
	logic [PTR_W-1:0]       head_q;
	logic [CNT_W-1:0]       scan_q;
	logic [CNT_W-1:0]       rpos_q;
	logic                   rvalid_q;
	logic [KIND_W-1:0]      stage_q;
	logic [PERIOD_W-1:0]    counter_q;
	logic                   running_q;

	// result
	logic [KIND_W-1:0]   kind_q;
	logic [TARGET_W-1:0] target_q;
	logic                sent_q;

	logic [CH_W-1:0]        ch_ext;
	logic [TG_W-1:0]        rd_ext;
	logic [PERIOD_W:0]      cnt_inc;
	logic                   expire;
	logic                   scan_more;
	logic [PTR_W-1:0]       head_inc;
	logic                   rd_en;
	logic [PTR_W-1:0]       rd_addr;
	logic                   wr_en;
	logic [PTR_W-1:0]       wr_addr;
	logic [HANDLE_BITS-1:0] wr_data;
	logic [KIND_W-1:0]      next_kind;
	logic                   kind_found;

	// logical queue position to ring address
	function automatic logic [PTR_W-1:0] phys(
		input logic [PTR_W-1:0] hd,
		input logic [CNT_W-1:0] idx
	);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(hd) + (CNT_W+1)'(idx);
		if (s >= (CNT_W+1)'(QUEUE_DEPTH)) begin
			s = s - (CNT_W+1)'(QUEUE_DEPTH);
		end
		return s[PTR_W-1:0];
	endfunction

	assign ch_ext    = CH_W'(channel);
	assign rd_ext    = TG_W'(rdata_q);
	assign cnt_inc   = {1'b0, counter_q} + (PERIOD_W+1)'(1);
	assign expire    = cnt_inc >= {1'b0, period_q};
	assign scan_more = scan_q < fill_q;
	assign head_inc  = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);

	// first allowed kind at or after the current stage
	always_comb begin
		next_kind  = KIND_MODE;
		kind_found = 1'b0;
		for (int k = 1; k <= 5; k++) begin
			if (!kind_found && KIND_W'(k) >= stage_q &&
			    kind_allowed(KIND_W'(k), op_q, mask_q, has_ie_q, ie_needs_op_q, has_q_q)) begin
				kind_found = 1'b1;
				next_kind  = KIND_W'(k);
			end
		end
	end

	always_comb begin
		sts.running    = running_q;
		sts.expire     = expire;
		sts.fill_zero  = (fill_q == '0);
		sts.fill_one   = (fill_q == CNT_W'(1));
		sts.full       = (fill_q >= CNT_W'(QUEUE_DEPTH));
		sts.hit        = rvalid_q && (rdata_q == ch_q);
		sts.scan_end   = !rvalid_q && !scan_more;
		sts.stage_zero = (stage_q == KIND_MODE);
		sts.kind_found = kind_found;
	end

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = head_q;
		wr_en   = 1'b0;
		wr_addr = phys(head_q, fill_q);
		wr_data = ch_q;
		if (ctl.scan_step && scan_more) begin
			rd_en   = 1'b1;
			rd_addr = phys(head_q, scan_q);
		end
		if (ctl.head_read) begin
			rd_en   = 1'b1;
			rd_addr = head_q;
		end
		// move each later handle down by one place
		if (ctl.shift_wr && rvalid_q) begin
			wr_en   = 1'b1;
			wr_addr = phys(head_q, rpos_q - CNT_W'(1));
			wr_data = rdata_q;
		end
		if (ctl.append && !sts.full) begin
			wr_en   = 1'b1;
			wr_addr = phys(head_q, fill_q);
			wr_data = ch_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fifo_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= fifo_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			ch_q   <= ch_ext[HANDLE_BITS-1:0];
			op_q   <= me_op;
			link_q <= link_up;
		end
		if (ctl.emit) begin
			kind_q   <= sts.stage_zero ? KIND_MODE : next_kind;
			target_q <= rd_ext[TARGET_W-1:0];
			sent_q   <= link_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q      <= PERIOD_RESET;
			mask_q        <= '0;
			has_ie_q      <= 1'b0;
			ie_needs_op_q <= 1'b0;
			has_q_q       <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PERIOD:    period_q      <= cfg_data[PERIOD_W-1:0];
				REG_DIS_MASK:  mask_q        <= cfg_data[MASK_W-1:0];
				REG_HAS_IE:    has_ie_q      <= cfg_data[0];
				REG_IE_NEEDOP: ie_needs_op_q <= cfg_data[0];
				REG_HAS_Q:     has_q_q       <= cfg_data[0];
				default:       mask_q        <= mask_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			head_q    <= '0;
			scan_q    <= '0;
			rpos_q    <= '0;
			rvalid_q  <= 1'b0;
			stage_q   <= KIND_MODE;
			counter_q <= '0;
			running_q <= 1'b0;
		end else begin
			if (ctl.wipe) begin
				fill_q    <= '0;
				running_q <= 1'b0;
				counter_q <= '0;
				stage_q   <= KIND_MODE;
			end
			if (ctl.scan_start) begin
				scan_q   <= '0;
				rvalid_q <= 1'b0;
			end
			if (ctl.shift_start) begin
				scan_q   <= rpos_q + CNT_W'(1);
				rvalid_q <= 1'b0;
			end
			if (ctl.scan_step) begin
				rvalid_q <= scan_more;
				if (scan_more) begin
					scan_q <= scan_q + CNT_W'(1);
					rpos_q <= scan_q;
				end
			end
			if (ctl.append && !sts.full) begin
				fill_q <= fill_q + CNT_W'(1);
				if (!running_q) begin
					running_q <= 1'b1;
					counter_q <= '0;
				end
			end
			if (ctl.remove_done) begin
				fill_q <= fill_q - CNT_W'(1);
				if (sts.fill_one) begin
					running_q <= 1'b0;
					counter_q <= '0;
				end
			end
			if (ctl.tick) begin
				if (expire) begin
					counter_q <= '0;
					if (sts.fill_zero) begin
						running_q <= 1'b0;
					end
				end else begin
					counter_q <= cnt_inc[PERIOD_W-1:0];
				end
			end
			if (ctl.drop_head) begin
				head_q <= head_inc;
				fill_q <= fill_q - CNT_W'(1);
				if (sts.fill_one) begin
					running_q <= 1'b0;
					counter_q <= '0;
				end else begin
					stage_q <= KIND_MODE;
				end
			end
			if (ctl.emit) begin
				if (!link_q) begin
					// failed send clears the queue, the period timer and the stage
					fill_q    <= '0;
					running_q <= 1'b0;
					counter_q <= '0;
					stage_q   <= KIND_MODE;
				end else if (sts.stage_zero) begin
					stage_q <= KIND_E;
				end else if (next_kind == KIND_B) begin
					head_q  <= head_inc;
					fill_q  <= fill_q - CNT_W'(1);
					stage_q <= KIND_MODE;
				end else begin
					stage_q <= next_kind + KIND_W'(1);
				end
			end
		end
	end

	assign request_kind = kind_q;
	assign target       = target_q;
	assign sent         = sent_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue fill count above depth");

	a_stopped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> counter_q == '0)
		else $error("period counter nonzero while timer stopped");

	a_stage_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stage_q <= KIND_B)
		else $error("request stage out of range");

	a_fail_wipes: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit && !link_q |=> fill_q == '0 && !running_q)
		else $error("failed send did not clear the queue");

endmodule

`default_nettype wire
